FILE: rtl/uart_baud_divisor_select_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the baud divisor select unit
// Assertion wrappers that are compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef UART_BAUD_DIVISOR_SELECT_UNIT_MACROS_SVH
`define UART_BAUD_DIVISOR_SELECT_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every edge outside reset
`define UBDS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// condition must never be seen
`define UBDS_NEVER(label, clk, rst, cond) \
   `UBDS_ASSERT(label, clk, rst, !(cond))
`else
`define UBDS_ASSERT(label, clk, rst, prop)
`define UBDS_NEVER(label, clk, rst, cond)
`endif
`endif

FILE: rtl/ubds_pkg.sv
// ----------------------------------------------------------------------------
// ubds_pkg
// Shared widths, constants and codes of the baud divisor select unit.
// ----------------------------------------------------------------------------
`default_nettype none
package ubds_pkg;
   localparam int RATE_W = 22;
   localparam int FAC_W  = 24;            // rounded factor, up to 12M for a nonzero rate
   localparam int NUM_W  = 25;            // dividend width
   localparam int DEN_W  = 24;            // divisor width
   localparam int STAGES = NUM_W;         // one quotient bit per stage
   localparam int CODE_W = 2;
   localparam int SIDE_W = RATE_W + 2 * (FAC_W + CODE_W);
   localparam int REQ_W  = 24;
   localparam int RSP_W  = 24;

   localparam logic [NUM_W-1:0] BASE_CLOCK  = NUM_W'(6000000);
   localparam logic [NUM_W-1:0] BASE_DOUBLE = NUM_W'(12000000);
   localparam logic [CODE_W-1:0] PRESCALE_MAX = 2'd3;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_ZERO_RATE = 2'd1,
      STATUS_RANGE     = 2'd2
   } status_type;
endpackage
`default_nettype wire

FILE: rtl/ubds_div.sv
// ----------------------------------------------------------------------------
// ubds_div
// Restoring divider, one quotient bit per register stage, with sideband.
// ----------------------------------------------------------------------------
`default_nettype none
module ubds_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        en,
   input  wire logic                        in_valid,
   input  wire logic [ubds_pkg::NUM_W-1:0]  in_num,
   input  wire logic [ubds_pkg::DEN_W-1:0]  in_den,
   input  wire logic [ubds_pkg::SIDE_W-1:0] in_side,
   output logic                             out_valid,
   output logic [ubds_pkg::NUM_W-1:0]       out_quo,
   output logic [ubds_pkg::SIDE_W-1:0]      out_side
);
   localparam int N = ubds_pkg::STAGES;

   logic                         vld_ff  [N];
   logic [ubds_pkg::DEN_W-1:0]   rem_ff  [N];
   logic [ubds_pkg::NUM_W-1:0]   quo_ff  [N];
   logic [ubds_pkg::NUM_W-1:0]   num_ff  [N];
   logic [ubds_pkg::DEN_W-1:0]   den_ff  [N];
   logic [ubds_pkg::SIDE_W-1:0]  side_ff [N];

   logic                         p_vld  [N];
   logic [ubds_pkg::DEN_W-1:0]   p_rem  [N];
   logic [ubds_pkg::NUM_W-1:0]   p_quo  [N];
   logic [ubds_pkg::NUM_W-1:0]   p_num  [N];
   logic [ubds_pkg::DEN_W-1:0]   p_den  [N];
   logic [ubds_pkg::SIDE_W-1:0]  p_side [N];

   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_stage
         logic [ubds_pkg::DEN_W:0]   cand;
         logic                       ge;
         logic [ubds_pkg::DEN_W:0]   diff;

         // previous stage or the input
         if (g == 0) begin : g_first
            assign p_vld[g]  = in_valid;
            assign p_rem[g]  = '0;
            assign p_quo[g]  = '0;
            assign p_num[g]  = in_num;
            assign p_den[g]  = in_den;
            assign p_side[g] = in_side;
         end else begin : g_next
            assign p_vld[g]  = vld_ff[g-1];
            assign p_rem[g]  = rem_ff[g-1];
            assign p_quo[g]  = quo_ff[g-1];
            assign p_num[g]  = num_ff[g-1];
            assign p_den[g]  = den_ff[g-1];
            assign p_side[g] = side_ff[g-1];
         end

         // shift in next dividend bit, trial subtract
         assign cand = {p_rem[g], p_num[g][N-1-g]};
         assign ge   = cand >= {1'b0, p_den[g]};
         assign diff = cand - {1'b0, p_den[g]};

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[g] <= 1'b0;
            end else if (en) begin
               vld_ff[g] <= p_vld[g];
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[g]  <= ge ? diff[ubds_pkg::DEN_W-1:0] : cand[ubds_pkg::DEN_W-1:0];
               quo_ff[g]  <= {p_quo[g][ubds_pkg::NUM_W-2:0], ge};
               num_ff[g]  <= p_num[g];
               den_ff[g]  <= p_den[g];
               side_ff[g] <= p_side[g];
            end
         end
      end
   endgenerate

   assign out_valid = vld_ff[N-1];
   assign out_quo   = quo_ff[N-1];
   assign out_side  = side_ff[N-1];
endmodule
`default_nettype wire

FILE: rtl/ubds_reduce.sv
// ----------------------------------------------------------------------------
// ubds_reduce
// Registered prescaler reduction of one candidate factor, builds next divide.
// ----------------------------------------------------------------------------
`default_nettype none
module ubds_reduce (
   input  wire logic                        clock,
   input  wire logic                        en,
   input  wire logic [ubds_pkg::NUM_W-1:0]  base,
   input  wire logic [ubds_pkg::NUM_W-1:0]  fac_raw,
   output logic [ubds_pkg::FAC_W-1:0]       fac,
   output logic [ubds_pkg::CODE_W-1:0]      code,
   output logic [ubds_pkg::NUM_W-1:0]       num,
   output logic [ubds_pkg::DEN_W-1:0]       den
);
   logic [ubds_pkg::FAC_W-1:0]  fac_in, fac_ff;
   logic [ubds_pkg::CODE_W-1:0] code_in, code_ff;
   logic [ubds_pkg::DEN_W-1:0]  den_in, den_ff;
   logic [ubds_pkg::NUM_W-1:0]  num_in, num_ff;
   logic [4:0]                  shamt;

   // up to three shifts by 3 while the factor exceeds a byte
   always_comb begin
      fac_in  = fac_raw[ubds_pkg::FAC_W-1:0];
      code_in = ubds_pkg::PRESCALE_MAX;
      for (int i = 0; i < 3; i++) begin
         if (fac_in > ubds_pkg::FAC_W'(8'hff) && code_in != '0) begin
            fac_in  = fac_in >> 3;
            code_in = code_in - 2'd1;
         end
      end
      shamt  = 5'(2'(ubds_pkg::PRESCALE_MAX - code_in)) * 5'd3;
      den_in = fac_in << shamt;
      num_in = base + ubds_pkg::NUM_W'(den_in >> 1);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fac_ff  <= fac_in;
         code_ff <= code_in;
         den_ff  <= den_in;
         num_ff  <= num_in;
      end
   end

   assign fac  = fac_ff;
   assign code = code_ff;
   assign num  = num_ff;
   assign den  = den_ff;
endmodule
`default_nettype wire

FILE: rtl/uart_baud_divisor_select_unit.sv
// Throughput: one word per cycle; a stall on the response side freezes all stages.
// Latency is set by two 25-stage bit-per-stage dividers in series, plus the
// reduction register between them and the output register.
// Reset: synchronous, active high; clears all valid bits, payload is not reset.
// ----------------------------------------------------------------------------
// uart_baud_divisor_select_unit
// Maps a requested baud rate to a UART clock setting word or an error status.
// ----------------------------------------------------------------------------
`default_nettype none
`include "uart_baud_divisor_select_unit_macros.svh"
module uart_baud_divisor_select_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [ubds_pkg::REQ_W-1:0]  req_tdata,  // [21:0] line_rate
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [ubds_pkg::RSP_W-1:0]       rsp_tdata   // [15:0] setting_word, [17:16] status
);
   localparam int RW = ubds_pkg::RATE_W;
   localparam int FW = ubds_pkg::FAC_W;
   localparam int CW = ubds_pkg::CODE_W;
   localparam int NW = ubds_pkg::NUM_W;

   logic en;
   logic [RW-1:0] rate;

   logic a1_v, a2_v;
   logic [NW-1:0] a1_q, a2_q;
   logic [ubds_pkg::SIDE_W-1:0] a1_s, a2_s;

   logic mid_v_ff;
   logic [RW-1:0] mid_rate_ff;
   logic [FW-1:0] r1_fac, r2_fac;
   logic [CW-1:0] r1_code, r2_code;
   logic [NW-1:0] r1_num, r2_num;
   logic [ubds_pkg::DEN_W-1:0] r1_den, r2_den;

   logic b1_v, b2_v;
   logic [NW-1:0] b1_q, b2_q;
   logic [ubds_pkg::SIDE_W-1:0] b1_s, b2_s;

   logic [RW-1:0] f_rate;
   logic [FW-1:0] f_fac1, f_fac2, best_fac;
   logic [CW-1:0] f_code1, f_code2, best_code;
   logic [NW-1:0] err1, err2;
   logic dbl;

   logic out_v_ff, out_v_in;
   logic [15:0] word_ff, word_in;
   ubds_pkg::status_type status_ff, status_in;

   // global advance: hold everything while the output word waits
   assign en         = !out_v_ff || rsp_tready;
   assign req_tready = en;
   assign rate       = req_tdata[RW-1:0];

   // first pass: rounded base / rate for both bases
   ubds_div u_div_a1 (
      .clock, .reset, .en, .in_valid(req_tvalid && req_tready),
      .in_num(ubds_pkg::BASE_CLOCK + NW'(rate >> 1)), .in_den(ubds_pkg::DEN_W'(rate)),
      .in_side(ubds_pkg::SIDE_W'(rate)),
      .out_valid(a1_v), .out_quo(a1_q), .out_side(a1_s)
   );
   ubds_div u_div_a2 (
      .clock, .reset, .en, .in_valid(req_tvalid && req_tready),
      .in_num(ubds_pkg::BASE_DOUBLE + NW'(rate >> 1)), .in_den(ubds_pkg::DEN_W'(rate)),
      .in_side(ubds_pkg::SIDE_W'(rate)),
      .out_valid(a2_v), .out_quo(a2_q), .out_side(a2_s)
   );

   // prescaler reduction stage
   ubds_reduce u_red1 (
      .clock, .en, .base(ubds_pkg::BASE_CLOCK), .fac_raw(a1_q),
      .fac(r1_fac), .code(r1_code), .num(r1_num), .den(r1_den)
   );
   ubds_reduce u_red2 (
      .clock, .en, .base(ubds_pkg::BASE_DOUBLE), .fac_raw(a2_q),
      .fac(r2_fac), .code(r2_code), .num(r2_num), .den(r2_den)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_v_ff <= 1'b0;
      end else if (en) begin
         mid_v_ff <= a1_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mid_rate_ff <= a1_s[RW-1:0];
      end
   end

   // second pass: achieved rate base / (factor * scale), rounded
   ubds_div u_div_b1 (
      .clock, .reset, .en, .in_valid(mid_v_ff),
      .in_num(r1_num), .in_den(r1_den),
      .in_side({r2_code, r2_fac, r1_code, r1_fac, mid_rate_ff}),
      .out_valid(b1_v), .out_quo(b1_q), .out_side(b1_s)
   );
   ubds_div u_div_b2 (
      .clock, .reset, .en, .in_valid(mid_v_ff),
      .in_num(r2_num), .in_den(r2_den),
      .in_side({r2_code, r2_fac, r1_code, r1_fac, mid_rate_ff}),
      .out_valid(b2_v), .out_quo(b2_q), .out_side(b2_s)
   );

   // error compare, candidate choice and word packing
   always_comb begin
      {f_code2, f_fac2, f_code1, f_fac1, f_rate} = b1_s;
      err1 = (b1_q > NW'(f_rate)) ? b1_q - NW'(f_rate) : NW'(f_rate) - b1_q;
      err2 = (b2_q > NW'(f_rate)) ? b2_q - NW'(f_rate) : NW'(f_rate) - b2_q;
      dbl  = (f_fac2 > FW'(8)) && (err2 < err1);
      best_fac  = dbl ? f_fac2 : f_fac1;
      best_code = dbl ? f_code2 : f_code1;
      out_v_in  = b1_v;
      if (f_rate == '0) begin
         status_in = ubds_pkg::STATUS_ZERO_RATE;
         word_in   = '0;
      end else if (best_fac < FW'(2) || best_fac > FW'(8'hff)) begin
         status_in = ubds_pkg::STATUS_RANGE;
         word_in   = '0;
      end else begin
         status_in = ubds_pkg::STATUS_OK;
         word_in   = {8'(9'h100 - 9'(best_fac)), 1'b1, 4'b0000, dbl, best_code};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         word_ff   <= word_in;
         status_ff <= status_in;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {6'b0, status_ff, word_ff};

   // parallel dividers stay in lockstep
   `UBDS_ASSERT(a_pass1_sync, clock, reset, (a1_v == a2_v) && (!a1_v || a1_s == a2_s))
   `UBDS_ASSERT(a_pass2_sync, clock, reset, (b1_v == b2_v) && (!b1_v || b1_s == b2_s))
   // good word always carries the fixed marker bit
   `UBDS_ASSERT(a_ok_marker, clock, reset,
      (out_v_ff && status_ff == ubds_pkg::STATUS_OK) |-> word_ff[7])
   // rejected word is all zero
   `UBDS_NEVER(a_err_word, clock, reset,
      out_v_ff && status_ff != ubds_pkg::STATUS_OK && word_ff != '0)
endmodule
`default_nettype wire
